FILE: hdl/dfd_pkg.sv
`default_nettype none

package dfd_pkg;

    localparam int DISPLAY_DIGITS = 8;
    localparam int DIGIT_W        = 4;
    localparam int BCD_ENTRIES    = 128;

    localparam logic [3:0] SYM_BLANK = 4'd10;
    localparam logic [3:0] SYM_MINUS = 4'd11;

    localparam logic [1:0] SIGN_MINUS = 2'd0;
    localparam logic [1:0] SIGN_BLANK = 2'd1;

    // One formatting request as it travels down the digit split pipeline.
    typedef struct packed {
        logic [2:0] device_id;
        logic [3:0] start_position;
        logic [3:0] field_length;
        logic [3:0] decimal_power;
        logic [1:0] sign_mode;
        logic       show_digit_at_point;
        logic       point_at_units;
    } req_t;

    // Index 0 is the units digit.
    typedef logic [DISPLAY_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    // Tens digit in the upper nibble, units digit in the lower nibble.
    typedef logic [BCD_ENTRIES-1:0][7:0] bcd_table_t;

    function automatic bcd_table_t build_bcd_table();
        bcd_table_t tbl;
        logic [3:0] tens;
        logic [3:0] units;
        tens  = '0;
        units = '0;
        for (int k = 0; k < BCD_ENTRIES; k++)
        begin
            tbl[k] = {tens, units};
            if (units == 4'd9)
            begin
                units = '0;
                tens  = tens + 4'd1;
            end
            else
            begin
                units = units + 4'd1;
            end
        end
        return tbl;
    endfunction

    localparam bcd_table_t BCD_TABLE = build_bcd_table();

endpackage

`default_nettype wire

FILE: hdl/dfd_digit_split.sv
`default_nettype none

module dfd_digit_split
    import dfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire req_t        in_req,
    input  wire logic [30:0] in_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output req_t             out_req,
    output digits_t          out_digits
);

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy5;

    req_t req0_reg, req1_reg, req2_reg, req3_reg, req4_reg, req5_reg;

    logic [30:0] num0_reg;
    logic [30:0] num1_reg;
    logic [4:0]  qe1_reg;
    logic [26:0] r2_reg;
    logic [26:0] r3_reg;
    logic [13:0] hi3_reg;
    logic [13:0] hi4_reg;
    logic [13:0] lo4_reg;
    logic [13:0] hi5_reg;
    logic [13:0] lo5_reg;
    logic [6:0]  qh5_reg;
    logic [6:0]  ql5_reg;

    logic [16:0] t_prod0;
    logic [4:0]  qe0;
    logic [30:0] q_prod1;
    logic [30:0] r_raw1;
    logic [30:0] r_cor1;
    logic [58:0] hi_prod2;
    logic [26:0] lo_full3;
    logic [26:0] qh_prod4;
    logic [26:0] ql_prod4;
    logic [13:0] rh_full5;
    logic [13:0] rl_full5;
    logic [7:0]  pair_qh, pair_rh, pair_ql, pair_rl;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_stall = !rdy0;

    // Estimate of number / 10^8 from the top eleven bits; it is never high
    // and at most one short, so one conditional subtract fixes it.
    assign t_prod0 = 17'(num0_reg[30:20]) * 17'd42;
    assign qe0     = t_prod0[16:12];

    assign q_prod1 = 31'(qe1_reg) * 31'd100000000;
    assign r_raw1  = num1_reg - q_prod1;
    assign r_cor1  = (r_raw1 >= 31'd100000000) ? (r_raw1 - 31'd100000000) : r_raw1;

    // Exact division by 10000 through a reciprocal.
    assign hi_prod2 = 59'(r2_reg) * 59'd3518437209;

    assign lo_full3 = r3_reg - 27'(hi3_reg) * 27'd10000;

    // Exact division by 100 for values below 10000.
    assign qh_prod4 = 27'(hi4_reg) * 27'd5243;
    assign ql_prod4 = 27'(lo4_reg) * 27'd5243;

    assign rh_full5 = hi5_reg - 14'(qh5_reg) * 14'd100;
    assign rl_full5 = lo5_reg - 14'(ql5_reg) * 14'd100;

    assign pair_qh = BCD_TABLE[qh5_reg];
    assign pair_rh = BCD_TABLE[rh_full5[6:0]];
    assign pair_ql = BCD_TABLE[ql5_reg];
    assign pair_rl = BCD_TABLE[rl_full5[6:0]];

    assign out_valid  = v5_reg;
    assign out_req    = req5_reg;
    assign out_digits = {pair_qh[7:4], pair_qh[3:0], pair_rh[7:4], pair_rh[3:0],
                         pair_ql[7:4], pair_ql[3:0], pair_rl[7:4], pair_rl[3:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= in_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            req0_reg <= in_req;
            num0_reg <= in_number;
        end
        if (rdy1)
        begin
            req1_reg <= req0_reg;
            num1_reg <= num0_reg;
            qe1_reg  <= qe0;
        end
        if (rdy2)
        begin
            req2_reg <= req1_reg;
            r2_reg   <= r_cor1[26:0];
        end
        if (rdy3)
        begin
            req3_reg <= req2_reg;
            r3_reg   <= r2_reg;
            hi3_reg  <= hi_prod2[58:45];
        end
        if (rdy4)
        begin
            req4_reg <= req3_reg;
            hi4_reg  <= hi3_reg;
            lo4_reg  <= lo_full3[13:0];
        end
        if (rdy5)
        begin
            req5_reg <= req4_reg;
            hi5_reg  <= hi4_reg;
            lo5_reg  <= lo4_reg;
            qh5_reg  <= qh_prod4[25:19];
            ql5_reg  <= ql_prod4[25:19];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dfd_emitter.sv
`default_nettype none

module dfd_emitter
    import dfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire req_t    in_req,
    input  wire digits_t in_digits,
    output logic         out_valid,
    input  wire logic    out_stall,
    output logic [2:0]   target_device,
    output logic [2:0]   digit_position,
    output logic [3:0]   symbol,
    output logic         point_on,
    output logic         write_enable,
    output logic         start_error,
    output logic         length_trimmed,
    output logic         sign_error,
    output logic         last
);

    // Request decode at load time.
    logic       ld_start_err;
    logic [3:0] ld_start;
    logic [4:0] ld_sum;
    logic       ld_trim;
    logic [3:0] ld_len;
    logic [3:0] ld_end;
    logic       ld_sign_req;
    logic       ld_has_sign;
    logic       ld_sign_err;
    logic [3:0] ld_sign_pos;

    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    logic [3:0] i_reg;
    logic [3:0] end_reg;
    logic [2:0] dev_reg;
    logic [3:0] pw_reg;
    logic       lead_reg;
    logic       units_reg;
    logic       minus_reg;
    logic       has_sign_reg;
    logic [2:0] sign_pos_reg;
    logic       se_reg;
    logic       lt_reg;
    logic       sg_reg;
    digits_t    digits_reg;

    logic       out_adv;
    logic       gen;
    logic       gen_last;
    logic       load;
    logic       in_digits_phase;
    logic       point_match;
    logic [3:0] ai;
    logic [3:0] pos_full;
    logic [3:0] digit_val;

    logic [2:0] res_pos;
    logic [3:0] res_sym;
    logic       res_pt;
    logic       res_we;

    always_comb
    begin
        ld_start_err = (in_req.start_position == 4'd0)
                    || (in_req.start_position > 4'(DISPLAY_DIGITS));
        ld_start     = ld_start_err ? 4'd1 : in_req.start_position;
        ld_sum       = 5'(ld_start) + 5'(in_req.field_length);
        ld_trim      = ld_sum > 5'(DISPLAY_DIGITS + 1);
        ld_len       = ld_trim ? (4'(DISPLAY_DIGITS + 1) - ld_start) : in_req.field_length;
        ld_end       = ld_start + ld_len;
        ld_sign_req  = (in_req.sign_mode == SIGN_MINUS) || (in_req.sign_mode == SIGN_BLANK);
        ld_sign_err  = ld_sign_req && (ld_start == 4'd1);
        ld_has_sign  = ld_sign_req && (ld_start != 4'd1);
        ld_sign_pos  = 4'(DISPLAY_DIGITS + 1) - ld_start;
    end

    // A field position i matches the point when i + power + 1 lands on the end.
    always_comb
    begin
        in_digits_phase = i_reg < end_reg;
        point_match     = (5'(i_reg) + 5'(pw_reg) + 5'd1) == 5'(end_reg);
        ai              = end_reg - 4'd1 - i_reg;
        pos_full        = 4'(DISPLAY_DIGITS) - i_reg;
        digit_val       = digits_reg[ai[2:0]];

        res_pos  = 3'd0;
        res_sym  = SYM_BLANK;
        res_pt   = 1'b0;
        res_we   = 1'b0;
        gen_last = 1'b1;

        priority if (in_digits_phase)
        begin
            res_pos  = pos_full[2:0];
            res_sym  = digit_val;
            res_we   = 1'b1;
            gen_last = ((i_reg + 4'd1) == end_reg) && !has_sign_reg;
            if (point_match && (pw_reg != 4'd0))
            begin
                res_pt = 1'b1;
                if (!lead_reg)
                begin
                    res_sym = SYM_BLANK;
                end
            end
            else if (point_match && units_reg)
            begin
                res_pt = 1'b1;
            end
        end
        else if (has_sign_reg)
        begin
            res_pos = sign_pos_reg;
            res_sym = minus_reg ? SYM_MINUS : SYM_BLANK;
            res_we  = 1'b1;
        end
        else
        begin
            // Nothing to write at all: one empty word carries the flags.
            res_pos = 3'd0;
            res_sym = SYM_BLANK;
        end
    end

    assign out_adv  = !out_valid_reg || !out_stall;
    assign gen      = busy_reg && out_adv;
    assign in_ready = !busy_reg || (gen && gen_last);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        if (gen && gen_last)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (gen)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            i_reg        <= ld_start;
            end_reg      <= ld_end;
            dev_reg      <= in_req.device_id;
            pw_reg       <= in_req.decimal_power;
            lead_reg     <= in_req.show_digit_at_point;
            units_reg    <= in_req.point_at_units;
            minus_reg    <= in_req.sign_mode == SIGN_MINUS;
            has_sign_reg <= ld_has_sign;
            sign_pos_reg <= ld_sign_pos[2:0];
            se_reg       <= ld_start_err;
            lt_reg       <= ld_trim;
            sg_reg       <= ld_sign_err;
            digits_reg   <= in_digits;
        end
        else if (gen && in_digits_phase)
        begin
            i_reg <= i_reg + 4'd1;
        end

        if (gen)
        begin
            target_device  <= dev_reg;
            digit_position <= res_pos;
            symbol         <= res_sym;
            point_on       <= res_pt;
            write_enable   <= res_we;
            start_error    <= se_reg;
            length_trimmed <= lt_reg;
            sign_error     <= sg_reg;
            last           <= gen_last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/decimal_field_display_formatter.sv
// A request's first word reaches the output through the digit split stages, the emitter's
// request registers and its output register. Throughput: one output word per cycle while
// out_stall is low; a request yields 1 to 8 words, and the next is taken with its last word.
// The six-stage digit split pipeline buffers up to six requests while the emitter works.
// Reset (rst_n, asynchronous, active low) empties the pipeline, emitter and output register.
`default_nettype none

module decimal_field_display_formatter
    import dfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  device_id,
    input  wire logic [30:0] number,
    input  wire logic [3:0]  start_position,
    input  wire logic [3:0]  field_length,
    input  wire logic [3:0]  decimal_power,
    input  wire logic [1:0]  sign_mode,
    input  wire logic        show_digit_at_point,
    input  wire logic        point_at_units,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       target_device,
    output logic [2:0]       digit_position,
    output logic [3:0]       symbol,
    output logic             point_on,
    output logic             write_enable,
    output logic             start_error,
    output logic             length_trimmed,
    output logic             sign_error,
    output logic             last
);

    req_t    in_req;
    req_t    split_req;
    digits_t split_digits;
    logic    split_valid;
    logic    emit_ready;

    always_comb
    begin
        in_req.device_id           = device_id;
        in_req.start_position      = start_position;
        in_req.field_length        = field_length;
        in_req.decimal_power       = decimal_power;
        in_req.sign_mode           = sign_mode;
        in_req.show_digit_at_point = show_digit_at_point;
        in_req.point_at_units      = point_at_units;
    end

    dfd_digit_split u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_req     (in_req),
        .in_number  (number),
        .out_valid  (split_valid),
        .out_ready  (emit_ready),
        .out_req    (split_req),
        .out_digits (split_digits)
    );

    dfd_emitter u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (split_valid),
        .in_ready       (emit_ready),
        .in_req         (split_req),
        .in_digits      (split_digits),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .target_device  (target_device),
        .digit_position (digit_position),
        .symbol         (symbol),
        .point_on       (point_on),
        .write_enable   (write_enable),
        .start_error    (start_error),
        .length_trimmed (length_trimmed),
        .sign_error     (sign_error),
        .last           (last)
    );

endmodule

`default_nettype wire
